### sv/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and constants of the JSON string unescaper: result status
// codes, the command record passed from the parser to the output stage, and
// the UTF-8 encoder.
// ----------------------------------------------------------------------------
package jsu_pkg;

    localparam int JSU_QDEPTH = 4;

    localparam logic [2:0] ST_DATA     = 3'd0;
    localparam logic [2:0] ST_CLOSE    = 3'd1;
    localparam logic [2:0] ST_BAD_HEX  = 3'd2;
    localparam logic [2:0] ST_BAD_SURR = 3'd3;
    localparam logic [2:0] ST_BAD_CP   = 3'd4;
    localparam logic [2:0] ST_UNTERM   = 3'd5;

    typedef struct packed {
        logic [7:0] data;
        logic [2:0] status;
    } t_item;

    typedef struct packed {
        logic [2:0]      cnt;
        t_item [3:0]     item;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic t_cmd f_utf8(logic [20:0] cp);
        t_cmd r;
        r = '0;
        if (cp < 21'h80) begin
            r.cnt     = 3'd1;
            r.item[0] = '{cp[7:0], ST_DATA};
        end else if (cp < 21'h800) begin
            r.cnt     = 3'd2;
            r.item[0] = '{8'hC0 | {3'b000, cp[10:6]}, ST_DATA};
            r.item[1] = '{8'h80 | {2'b00, cp[5:0]}, ST_DATA};
        end else if (cp < 21'h10000) begin
            r.cnt     = 3'd3;
            r.item[0] = '{8'hE0 | {4'b0000, cp[15:12]}, ST_DATA};
            r.item[1] = '{8'h80 | {2'b00, cp[11:6]}, ST_DATA};
            r.item[2] = '{8'h80 | {2'b00, cp[5:0]}, ST_DATA};
        end else begin
            r.cnt     = 3'd4;
            r.item[0] = '{8'hF0 | {5'b00000, cp[20:18]}, ST_DATA};
            r.item[1] = '{8'h80 | {2'b00, cp[17:12]}, ST_DATA};
            r.item[2] = '{8'h80 | {2'b00, cp[11:6]}, ST_DATA};
            r.item[3] = '{8'h80 | {2'b00, cp[5:0]}, ST_DATA};
        end
        return r;
    endfunction

endpackage

### sv/jsu_front.sv
// ----------------------------------------------------------------------------
// jsu_front
// Escape parser. Takes one string byte per cycle while the command queue
// is not full, tracks the escape and surrogate state, and turns each byte
// into a command of zero to four result items for the output stage.
// ----------------------------------------------------------------------------
module jsu_front
    import jsu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    input  logic       i_push,
    input  logic [7:0] i_byte,
    input  t_q_stat    i_qstat,
    output logic       o_wr,
    output t_cmd       o_cmd
);

    localparam logic [7:0] C_BSL   = 8'h5C;
    localparam logic [7:0] C_QUOTE = 8'h22;
    localparam logic [7:0] C_SLASH = 8'h2F;
    localparam logic [7:0] C_B     = 8'h62;
    localparam logic [7:0] C_F     = 8'h66;
    localparam logic [7:0] C_N     = 8'h6E;
    localparam logic [7:0] C_R     = 8'h72;
    localparam logic [7:0] C_T     = 8'h74;
    localparam logic [7:0] C_U     = 8'h75;

    typedef enum logic [11:0] {
        PH_PLAIN = 12'b0000_0000_0001,
        PH_ESC   = 12'b0000_0000_0010,
        PH_HI0   = 12'b0000_0000_0100,
        PH_HI1   = 12'b0000_0000_1000,
        PH_HI2   = 12'b0000_0001_0000,
        PH_HI3   = 12'b0000_0010_0000,
        PH_WBS   = 12'b0000_0100_0000,
        PH_WU    = 12'b0000_1000_0000,
        PH_LO0   = 12'b0001_0000_0000,
        PH_LO1   = 12'b0010_0000_0000,
        PH_LO2   = 12'b0100_0000_0000,
        PH_LO3   = 12'b1000_0000_0000
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [15:0] r_high, n_high;
    logic [15:0] r_low, n_low;
    logic        r_mode;
    logic        w_acc;
    logic [4:0]  w_hex;
    logic        w_hv;
    logic [15:0] w_hunit;
    logic [15:0] w_lunit;
    t_cmd        v_cmd;

    function automatic logic [4:0] f_hex(logic [7:0] b);
        logic [4:0] r;
        r = 5'h10;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b0, b[3:0]};
        end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
            r = {1'b0, b[3:0] + 4'd9};
        end
        return r;
    endfunction

    function automatic t_cmd f_push(t_cmd cmd, logic [7:0] b, logic [2:0] st);
        t_cmd r;
        r = cmd;
        r.item[cmd.cnt[1:0]] = '{b, st};
        r.cnt = cmd.cnt + 3'd1;
        return r;
    endfunction

    function automatic t_cmd f_plain(t_cmd cmd, logic [7:0] b);
        t_cmd r;
        r = cmd;
        if (b == 8'h00) begin
            r = f_push(cmd, 8'h00, ST_UNTERM);
        end else if (b == C_QUOTE) begin
            r = f_push(cmd, 8'h00, ST_CLOSE);
        end else if (b != C_BSL) begin
            r = f_push(cmd, b, ST_DATA);
        end
        return r;
    endfunction

    assign w_acc   = i_push & ~i_qstat.full;
    assign w_hex   = f_hex(i_byte);
    assign w_hv    = ~w_hex[4];
    assign w_hunit = {r_high[11:0], w_hex[3:0]};
    assign w_lunit = {r_low[11:0], w_hex[3:0]};

    always_comb begin
        v_cmd   = '0;
        n_phase = r_phase;
        n_high  = r_high;
        n_low   = r_low;
        unique case (r_phase)
            PH_ESC: begin
                n_phase = PH_PLAIN;
                unique case (i_byte)
                    C_BSL, C_SLASH, C_QUOTE: v_cmd = f_push(v_cmd, i_byte, ST_DATA);
                    C_B: v_cmd = f_push(v_cmd, 8'h08, ST_DATA);
                    C_F: v_cmd = f_push(v_cmd, 8'h0C, ST_DATA);
                    C_N: v_cmd = f_push(v_cmd, 8'h0A, ST_DATA);
                    C_R: v_cmd = f_push(v_cmd, 8'h0D, ST_DATA);
                    C_T: v_cmd = f_push(v_cmd, 8'h09, ST_DATA);
                    C_U: begin
                        if (r_mode) begin
                            n_phase = PH_HI0;
                            n_high  = '0;
                        end else begin
                            v_cmd = f_push(v_cmd, C_BSL, ST_DATA);
                            v_cmd = f_push(v_cmd, C_U, ST_DATA);
                        end
                    end
                    default: begin
                        v_cmd = f_push(v_cmd, C_BSL, ST_DATA);
                        v_cmd = f_plain(v_cmd, i_byte);
                        if (i_byte == C_BSL) begin
                            n_phase = PH_ESC;
                        end
                    end
                endcase
            end
            PH_HI0, PH_HI1, PH_HI2: begin
                if (!w_hv) begin
                    v_cmd   = f_push(v_cmd, 8'h00, ST_BAD_HEX);
                    n_phase = PH_PLAIN;
                end else begin
                    n_high  = w_hunit;
                    n_phase = (r_phase == PH_HI0) ? PH_HI1 :
                              (r_phase == PH_HI1) ? PH_HI2 : PH_HI3;
                end
            end
            PH_HI3: begin
                n_phase = PH_PLAIN;
                if (!w_hv) begin
                    v_cmd = f_push(v_cmd, 8'h00, ST_BAD_HEX);
                end else begin
                    n_high = w_hunit;
                    if (w_hunit[15:10] == 6'b110110) begin
                        n_phase = PH_WBS;
                    end else if (w_hunit[15:10] == 6'b110111) begin
                        v_cmd = f_push(v_cmd, 8'h00, ST_BAD_CP);
                    end else begin
                        v_cmd = f_utf8({5'b00000, w_hunit});
                    end
                end
            end
            PH_WBS: begin
                if (i_byte == C_BSL) begin
                    n_phase = PH_WU;
                end else begin
                    v_cmd   = f_push(v_cmd, 8'h00, ST_BAD_SURR);
                    n_phase = PH_PLAIN;
                end
            end
            PH_WU: begin
                if (i_byte == C_U) begin
                    n_phase = PH_LO0;
                    n_low   = '0;
                end else begin
                    v_cmd   = f_push(v_cmd, 8'h00, ST_BAD_SURR);
                    n_phase = PH_PLAIN;
                end
            end
            PH_LO0, PH_LO1, PH_LO2: begin
                if (!w_hv) begin
                    v_cmd   = f_push(v_cmd, 8'h00, ST_BAD_SURR);
                    n_phase = PH_PLAIN;
                end else begin
                    n_low   = w_lunit;
                    n_phase = (r_phase == PH_LO0) ? PH_LO1 :
                              (r_phase == PH_LO1) ? PH_LO2 : PH_LO3;
                end
            end
            PH_LO3: begin
                n_phase = PH_PLAIN;
                if (!w_hv || w_lunit[15:10] != 6'b110111) begin
                    v_cmd = f_push(v_cmd, 8'h00, ST_BAD_SURR);
                end else begin
                    n_low = w_lunit;
                    v_cmd = f_utf8(21'h10000 + {1'b0, r_high[9:0], w_lunit[9:0]});
                end
            end
            default: begin
                v_cmd   = f_plain(v_cmd, i_byte);
                n_phase = (i_byte == C_BSL) ? PH_ESC : PH_PLAIN;
            end
        endcase
    end

    assign o_cmd = v_cmd;
    assign o_wr  = w_acc & (v_cmd.cnt != 3'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PLAIN;
            r_high  <= '0;
            r_low   <= '0;
            r_mode  <= 1'b1;
        end else begin
            if (w_acc) begin
                r_phase <= n_phase;
                r_high  <= n_high;
                r_low   <= n_low;
            end
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
        end
    end

endmodule

### sv/jsu_queue.sv
// ----------------------------------------------------------------------------
// jsu_queue
// Short command queue between the parser and the output stage, so that
// either side can stall without holding up the other.
// ----------------------------------------------------------------------------
module jsu_queue
    import jsu_pkg::*;
#(
    parameter int DEPTH = JSU_QDEPTH
)
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_wr,
    input  t_cmd    i_cmd,
    input  logic    i_rd,
    output t_cmd    o_head,
    output t_q_stat o_stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;

    function automatic logic [AW-1:0] f_next(logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_head       = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == CW'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr) begin
                r_wp <= f_next(r_wp);
            end
            if (i_rd) begin
                r_rp <= f_next(r_rp);
            end
            if (i_wr && !i_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_wr && i_rd) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("queue count above depth");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_wr && o_stat.full))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_rd && o_stat.empty))
        else $error("queue read while empty");

endmodule

### sv/jsu_back.sv
// ----------------------------------------------------------------------------
// jsu_back
// Output stage. Walks the head command's items into the result register
// one per cycle, unless an unpopped result holds it, marking each last item.
// ----------------------------------------------------------------------------
module jsu_back
    import jsu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_head,
    input  t_q_stat    i_qstat,
    output logic       o_qrd,
    input  logic       i_pop,
    output logic       o_empty,
    output logic [7:0] o_out_byte,
    output logic [2:0] o_status,
    output logic       o_last
);

    logic [1:0] r_idx;
    logic       r_ov;
    logic [7:0] r_byte;
    logic [2:0] r_st;
    logic       r_last;
    logic       w_load;
    logic       w_end;
    t_item      w_item;

    assign w_load = ~i_qstat.empty & (~r_ov | i_pop);
    assign w_end  = ({1'b0, r_idx} + 3'd1) == i_head.cnt;
    assign w_item = i_head.item[r_idx];
    assign o_qrd  = w_load & w_end;

    assign o_empty    = ~r_ov;
    assign o_out_byte = r_byte;
    assign o_status   = r_st;
    assign o_last     = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_ov  <= 1'b0;
        end else begin
            r_ov <= w_load | (r_ov & ~i_pop);
            if (w_load) begin
                r_idx <= w_end ? 2'd0 : r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte <= w_item.data;
            r_st   <= w_item.status;
            r_last <= w_end;
        end
    end

    a_rd_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_qrd |-> w_load && !i_qstat.empty)
        else $error("command retired without loading its last item");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_st != ST_DATA |-> r_byte == 8'h00 && r_last)
        else $error("status result carries data or is not final");

endmodule

### sv/json_string_unescape_core.sv
// ----------------------------------------------------------------------------
// json_string_unescape_core
// JSON string body unescaper with optional \uXXXX to UTF-8 decoding.
//
//   Channel   Direction  Handshake           Payload
//   input     in         push / full         i_in_byte
//   result    out        empty / pop         o_out_byte, o_status, o_last
//   config    in         i_cfg_we            i_cfg_wdata (unicode mode)
//
// The parser takes one byte per cycle unless full; each byte yields zero to
// four results. The output stage delivers one result per cycle while they
// are popped; a byte passes the queue and result register to the ports.
// Full rises when the command queue holds QDEPTH commands.
// Reset is synchronous; no clearing pass follows.
// ----------------------------------------------------------------------------
module json_string_unescape_core
    import jsu_pkg::*;
#(
    parameter int QDEPTH = JSU_QDEPTH
)
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_in_byte,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_byte,
    output logic [2:0] o_status,
    output logic       o_last
);

    t_cmd    w_cmd;
    t_cmd    w_head;
    t_q_stat w_qstat;
    logic    w_wr;
    logic    w_rd;

    assign full = w_qstat.full;

    jsu_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_push      (push),
        .i_byte      (i_in_byte),
        .i_qstat     (w_qstat),
        .o_wr        (w_wr),
        .o_cmd       (w_cmd)
    );

    jsu_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wr),
        .i_cmd   (w_cmd),
        .i_rd    (w_rd),
        .o_head  (w_head),
        .o_stat  (w_qstat)
    );

    jsu_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (w_head),
        .i_qstat    (w_qstat),
        .o_qrd      (w_rd),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_out_byte (o_out_byte),
        .o_status   (o_status),
        .o_last     (o_last)
    );

endmodule
